@@ src/fmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmq_pkg
// Shared types and constants for the mutex with FIFO wait and condition queues.
// ----------------------------------------------------------------------------
package fmq_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 2;

  // ids at or above this are refused
  localparam int PROC_COUNT = 64;

  localparam logic [OP_W-1:0] OP_MUTEX_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOCK        = 3'd1;
  localparam logic [OP_W-1:0] OP_UNLOCK      = 3'd2;
  localparam logic [OP_W-1:0] OP_COND_INIT   = 3'd3;
  localparam logic [OP_W-1:0] OP_COND_WAIT   = 3'd4;
  localparam logic [OP_W-1:0] OP_COND_SIGNAL = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] requester;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                granted;
    logic                woken_valid;
    logic [ID_W-1:0]     woken_id;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

@@ src/fmq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fmq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/fmq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmq_ctrl
// Handshake controller: accepts a request, runs the execute state, holds the
// result valid until it is taken.
// ----------------------------------------------------------------------------
module fmq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output fmq_pkg::cmd_t cmd
);
  import fmq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free   = !out_valid_r || !out_stall;
  assign in_stall    = !((state_r == S_IDLE) && slot_free);
  assign cmd.capture = in_valid && !in_stall;
  assign cmd.execute = (state_r == S_EXEC);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/fmq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmq_datapath
// Mutex and condition state, ring-buffer wait queues and result register.
// ----------------------------------------------------------------------------
module fmq_datapath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fmq_pkg::cmd_t cmd,
  input  fmq_pkg::req_t in_data,
  output fmq_pkg::rsp_t out_data
);
  import fmq_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [QW-1:0] LAST = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] WRAP = SW'(QUEUE_DEPTH);

  req_t req_r;
  rsp_t rsp_r, rsp_nxt;

  logic            mutex_ready_r, mutex_ready_nxt;
  logic            mutex_held_r, mutex_held_nxt;
  logic [ID_W-1:0] owner_r, owner_nxt;
  logic [QW-1:0]   lock_head_r, lock_head_nxt;
  logic [CW-1:0]   lock_cnt_r, lock_cnt_nxt;
  logic            cond_ready_r, cond_ready_nxt;
  logic [QW-1:0]   cond_head_r, cond_head_nxt;
  logic [CW-1:0]   cond_cnt_r, cond_cnt_nxt;

  logic [ID_W-1:0] lock_rd, cond_rd;
  logic [QW-1:0]   lock_tail, cond_tail;
  logic [SW-1:0]   lock_sum, cond_sum;
  logic [QW-1:0]   lock_head_adv, cond_head_adv;

  logic            lock_push, cond_push, cond_pop, do_release;
  logic [ID_W-1:0] lock_wdata;
  logic            req_ok, owns;
  logic [ID_W-1:0] w;

  fmq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_lock_q (
    .clk   (clk),
    .we    (cmd.execute && lock_push),
    .waddr (lock_tail),
    .wdata (lock_wdata),
    .raddr (lock_head_r),
    .rdata (lock_rd)
  );

  fmq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_cond_q (
    .clk   (clk),
    .we    (cmd.execute && cond_push),
    .waddr (cond_tail),
    .wdata (req_r.requester),
    .raddr (cond_head_r),
    .rdata (cond_rd)
  );

  assign lock_sum      = SW'(lock_head_r) + SW'(lock_cnt_r);
  assign cond_sum      = SW'(cond_head_r) + SW'(cond_cnt_r);
  assign lock_tail     = (lock_sum >= WRAP) ? QW'(lock_sum - WRAP) : QW'(lock_sum);
  assign cond_tail     = (cond_sum >= WRAP) ? QW'(cond_sum - WRAP) : QW'(cond_sum);
  assign lock_head_adv = (lock_head_r == LAST) ? '0 : lock_head_r + 1'b1;
  assign cond_head_adv = (cond_head_r == LAST) ? '0 : cond_head_r + 1'b1;

  assign req_ok = (32'(req_r.requester) < 32'(PROC_COUNT));
  assign owns   = mutex_held_r && (owner_r == req_r.requester);
  assign w      = cond_rd;

  always_comb begin
    mutex_ready_nxt = mutex_ready_r;
    mutex_held_nxt  = mutex_held_r;
    owner_nxt       = owner_r;
    lock_head_nxt   = lock_head_r;
    lock_cnt_nxt    = lock_cnt_r;
    cond_ready_nxt  = cond_ready_r;
    cond_head_nxt   = cond_head_r;
    cond_cnt_nxt    = cond_cnt_r;
    lock_push       = 1'b0;
    cond_push       = 1'b0;
    cond_pop        = 1'b0;
    do_release      = 1'b0;
    lock_wdata      = req_r.requester;
    rsp_nxt         = '0;
    rsp_nxt.status  = ST_OK;

    if (!req_ok) begin
      rsp_nxt.status = ST_REFUSED;
    end else begin
      case (req_r.op)
        OP_MUTEX_INIT: begin
          if (mutex_ready_r) begin
            rsp_nxt.status = ST_INIT;
          end else begin
            mutex_ready_nxt = 1'b1;
            mutex_held_nxt  = 1'b0;
            owner_nxt       = '0;
            lock_cnt_nxt    = '0;
            lock_head_nxt   = '0;
          end
        end
        OP_LOCK: begin
          if (!mutex_ready_r) begin
            rsp_nxt.status = ST_INIT;
          end else if (owns) begin
            rsp_nxt.status = ST_REFUSED;
          end else if (mutex_held_r) begin
            if (lock_cnt_r >= FULL) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              lock_push = 1'b1;
            end
          end else begin
            mutex_held_nxt = 1'b1;
            owner_nxt      = req_r.requester;
          end
        end
        OP_UNLOCK: begin
          if (!mutex_ready_r) begin
            rsp_nxt.status = ST_INIT;
          end else if (!owns) begin
            rsp_nxt.status = ST_REFUSED;
          end else begin
            do_release = 1'b1;
          end
        end
        OP_COND_INIT: begin
          if (cond_ready_r) begin
            rsp_nxt.status = ST_INIT;
          end else begin
            cond_ready_nxt = 1'b1;
            cond_cnt_nxt   = '0;
            cond_head_nxt  = '0;
          end
        end
        OP_COND_WAIT: begin
          if (!cond_ready_r) begin
            rsp_nxt.status = ST_INIT;
          end else if (!owns) begin
            rsp_nxt.status = ST_REFUSED;
          end else if (cond_cnt_r >= FULL) begin
            rsp_nxt.status = ST_FULL;
          end else begin
            do_release = 1'b1;
            cond_push  = 1'b1;
          end
        end
        OP_COND_SIGNAL: begin
          if (!cond_ready_r) begin
            rsp_nxt.status = ST_INIT;
          end else if (cond_cnt_r != '0) begin
            if (mutex_held_r && (owner_r == w)) begin
              cond_pop = 1'b1;
            end else if (mutex_held_r) begin
              if (lock_cnt_r >= FULL) begin
                rsp_nxt.status = ST_FULL;
              end else begin
                cond_pop   = 1'b1;
                lock_push  = 1'b1;
                lock_wdata = w;
              end
            end else begin
              cond_pop            = 1'b1;
              mutex_held_nxt      = 1'b1;
              owner_nxt           = w;
              rsp_nxt.woken_valid = 1'b1;
              rsp_nxt.woken_id    = w;
            end
          end
        end
        default: begin
          rsp_nxt.status = ST_REFUSED;
        end
      endcase
    end

    // hand-over to the head lock waiter, or release if none waits
    if (do_release) begin
      if (lock_cnt_r != '0) begin
        mutex_held_nxt      = 1'b1;
        owner_nxt           = lock_rd;
        lock_head_nxt       = lock_head_adv;
        lock_cnt_nxt        = lock_cnt_r - 1'b1;
        rsp_nxt.woken_valid = 1'b1;
        rsp_nxt.woken_id    = lock_rd;
      end else begin
        mutex_held_nxt = 1'b0;
        owner_nxt      = '0;
      end
    end
    if (lock_push) begin
      lock_cnt_nxt = lock_cnt_r + 1'b1;
    end
    if (cond_push) begin
      cond_cnt_nxt = cond_cnt_r + 1'b1;
    end
    if (cond_pop) begin
      cond_head_nxt = cond_head_adv;
      cond_cnt_nxt  = cond_cnt_r - 1'b1;
    end

    rsp_nxt.granted = mutex_held_nxt && (owner_nxt == req_r.requester);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mutex_ready_r <= 1'b0;
      mutex_held_r  <= 1'b0;
      owner_r       <= '0;
      lock_head_r   <= '0;
      lock_cnt_r    <= '0;
      cond_ready_r  <= 1'b0;
      cond_head_r   <= '0;
      cond_cnt_r    <= '0;
    end else if (cmd.execute) begin
      mutex_ready_r <= mutex_ready_nxt;
      mutex_held_r  <= mutex_held_nxt;
      owner_r       <= owner_nxt;
      lock_head_r   <= lock_head_nxt;
      lock_cnt_r    <= lock_cnt_nxt;
      cond_ready_r  <= cond_ready_nxt;
      cond_head_r   <= cond_head_nxt;
      cond_cnt_r    <= cond_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.execute) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_data = rsp_r;

endmodule

@@ src/fifo_mutex_with_condition_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mutex_with_condition_queue
// Hardware mutex with FIFO lock queue and one condition variable.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one request (op, requester). Each request
//   produces exactly one result on out_valid/out_stall/out_data (status,
//   granted, woken_valid, woken_id).
//   An accepted request runs in the execute state, which registers its result;
//   no new request is taken until it is done. The heads of the two wait-queue
//   RAMs are read before execute (registered read); the execute cycle updates
//   the state and writes at most one entry per queue.
//   A new request is taken while the previous result is still waiting only
//   if that result is taken in the same cycle; a stalled result holds and
//   the input stays stalled.
//   After reset the mutex and condition are uninitialized, both queues are
//   empty; queue RAM contents are never cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module fifo_mutex_with_condition_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fmq_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fmq_pkg::rsp_t out_data
);
  import fmq_pkg::*;

  cmd_t cmd;

  fmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fmq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mutex with FIFO lock queue and condition queue.
// A directed sequence walks the init checks, the ownership refusals, the
// hand-over on unlock and wait, and the signal paths with the mutex held. A
// long random run then mixes general traffic with bursts that fill the lock
// queue, fill the condition queue and drain them. Each request is predicted
// when accepted, and each result is compared field by field in order. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import fmq_pkg::*;

  localparam int QDEPTH    = 64;
  localparam int N_RANDOM  = 2000;
  localparam int LIMIT     = 1000000;
  localparam int N_DIRECT  = 25;

  localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

  typedef enum int {MODE_MIX, MODE_FILL_LOCK, MODE_FILL_COND, MODE_DRAIN} mode_t;

  class lock_tracker;
    logic             mutex_rdy = 1'b0;
    logic             held      = 1'b0;
    logic [ID_W-1:0]  owner     = '0;
    logic             cond_rdy  = 1'b0;
    logic [ID_W-1:0]  lock_q[$];
    logic [ID_W-1:0]  cond_q[$];
    rsp_t             expected_rsp[$];
    int               errors    = 0;

    function int pending();
      return expected_rsp.size();
    endfunction

    // owner leaves; head lock waiter, if any, takes the mutex directly
    function void pass_mutex(inout rsp_t res);
      if (lock_q.size() > 0) begin
        owner = lock_q.pop_front();
        held = 1'b1;
        res.woken_valid = 1'b1;
        res.woken_id = owner;
      end else begin
        held = 1'b0;
        owner = '0;
      end
    endfunction

    function rsp_t next_result(req_t r);
      rsp_t            res;
      logic            owns;
      logic [ID_W-1:0] w;
      res = '0;
      res.status = ST_OK;
      owns = held && owner == r.requester;
      if (int'(r.requester) >= PROC_COUNT) begin
        res.status = ST_REFUSED;
      end else begin
        case (r.op)
          OP_MUTEX_INIT: begin
            if (mutex_rdy) begin
              res.status = ST_INIT;
            end else begin
              mutex_rdy = 1'b1;
              held = 1'b0;
              owner = '0;
              lock_q.delete();
            end
          end
          OP_LOCK: begin
            if (!mutex_rdy) res.status = ST_INIT;
            else if (owns) res.status = ST_REFUSED;
            else if (held) begin
              if (lock_q.size() >= QDEPTH) res.status = ST_FULL;
              else lock_q.push_back(r.requester);
            end else begin
              held = 1'b1;
              owner = r.requester;
            end
          end
          OP_UNLOCK: begin
            if (!mutex_rdy) res.status = ST_INIT;
            else if (!owns) res.status = ST_REFUSED;
            else pass_mutex(res);
          end
          OP_COND_INIT: begin
            if (cond_rdy) begin
              res.status = ST_INIT;
            end else begin
              cond_rdy = 1'b1;
              cond_q.delete();
            end
          end
          OP_COND_WAIT: begin
            if (!cond_rdy) res.status = ST_INIT;
            else if (!owns) res.status = ST_REFUSED;
            else if (cond_q.size() >= QDEPTH) res.status = ST_FULL;
            else begin
              pass_mutex(res);
              cond_q.push_back(r.requester);
            end
          end
          OP_COND_SIGNAL: begin
            if (!cond_rdy) begin
              res.status = ST_INIT;
            end else if (cond_q.size() > 0) begin
              w = cond_q[0];
              if (held && owner == w) begin
                void'(cond_q.pop_front());
              end else if (held) begin
                if (lock_q.size() >= QDEPTH) begin
                  res.status = ST_FULL;
                end else begin
                  void'(cond_q.pop_front());
                  lock_q.push_back(w);
                end
              end else begin
                void'(cond_q.pop_front());
                held = 1'b1;
                owner = w;
                res.woken_valid = 1'b1;
                res.woken_id = w;
              end
            end
          end
          default: res.status = ST_REFUSED;
        endcase
      end
      res.granted = held && owner == r.requester;
      return res;
    endfunction

    function void note_request(req_t r);
      expected_rsp.push_back(next_result(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (expected_rsp.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      exp = expected_rsp.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.granted !== exp.granted) begin
        $error("granted: expected %0d, got %0d", exp.granted, got.granted);
        errors++;
      end
      if (got.woken_valid !== exp.woken_valid) begin
        $error("woken_valid: expected %0d, got %0d", exp.woken_valid, got.woken_valid);
        errors++;
      end
      if (got.woken_id !== exp.woken_id) begin
        $error("woken_id: expected %0d, got %0d", exp.woken_id, got.woken_id);
        errors++;
      end
    endfunction
  endclass

  localparam req_t DIRECTED [N_DIRECT] = '{
    '{OP_LOCK, 6'd0}, '{OP_UNLOCK, 6'd63}, '{OP_COND_WAIT, 6'd0}, '{OP_COND_SIGNAL, 6'd63},
    '{OP_UNDEF_A, 6'd21}, '{OP_UNDEF_B, 6'd42},
    '{OP_MUTEX_INIT, 6'd0}, '{OP_MUTEX_INIT, 6'd63},
    '{OP_COND_INIT, 6'd5}, '{OP_COND_INIT, 6'd5},
    '{OP_LOCK, 6'd63}, '{OP_LOCK, 6'd63}, '{OP_LOCK, 6'd0}, '{OP_LOCK, 6'd0},
    '{OP_UNLOCK, 6'd0}, '{OP_COND_WAIT, 6'd0}, '{OP_COND_SIGNAL, 6'd1},
    '{OP_COND_WAIT, 6'd63}, '{OP_COND_SIGNAL, 6'd7}, '{OP_UNLOCK, 6'd0}, '{OP_UNLOCK, 6'd0},
    '{OP_COND_WAIT, 6'd63}, '{OP_LOCK, 6'd63}, '{OP_COND_SIGNAL, 6'd42}, '{OP_UNLOCK, 6'd63}
  };

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  req_t  in_data;
  logic  out_valid;
  logic  out_stall;
  rsp_t  out_data;
  int    cycle_cnt = 0;

  lock_tracker sb;

  fifo_mutex_with_condition_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] id;
    if ($urandom_range(0, 9) < 7) id = ID_W'($urandom_range(0, 7));
    else id = ID_W'($urandom_range(0, 63));
    return id;
  endfunction

  function automatic req_t pick_request(mode_t mode);
    req_t r;
    int   roll;
    roll = $urandom_range(0, 99);
    r.requester = pick_id();
    r.op = OP_LOCK;
    case (mode)
      MODE_FILL_LOCK: begin
        if (roll >= 90) r.op = OP_COND_SIGNAL;
      end
      MODE_FILL_COND: begin
        if (sb.held && roll < 85) begin
          r.op = OP_COND_WAIT;
          r.requester = sb.owner;
        end
      end
      MODE_DRAIN: begin
        r.op = (roll < 50) ? OP_UNLOCK : OP_COND_SIGNAL;
        if (sb.held && roll < 45) r.requester = sb.owner;
      end
      default: begin
        if (roll < 10) r.op = OP_W'($urandom_range(0, 7));
        else if (roll < 45) r.op = OP_LOCK;
        else if (roll < 65) r.op = OP_UNLOCK;
        else if (roll < 80) r.op = OP_COND_WAIT;
        else r.op = OP_COND_SIGNAL;
        if (roll >= 45 && roll < 80 && sb.held && $urandom_range(0, 4) != 0)
          r.requester = sb.owner;
      end
    endcase
    return r;
  endfunction

  task automatic send_request(req_t r, int gap);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    int run;
    bit hold;
    out_stall <= 1'b0;
    forever begin
      hold = ($urandom_range(0, 2) == 0);
      run = hold ? idle_len() + 1 : $urandom_range(1, 30);
      repeat (run) begin
        @(posedge clk);
        out_stall <= hold;
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    mode_t mode;
    int    sent;
    int    seg;
    bit    calm;
    bit    paused;
    sb = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECT; i++) send_request(DIRECTED[i], idle_len());
    wait_drained();

    sent = 0;
    paused = 1'b0;
    while (sent < N_RANDOM) begin
      mode = mode_t'($urandom_range(0, 3));
      seg = (mode == MODE_FILL_COND) ? $urandom_range(60, 160) : $urandom_range(30, 120);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg; i++) send_request(pick_request(mode), calm ? 0 : idle_len());
      sent += seg;
      if (!paused && sent > N_RANDOM / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
